// ===== rtl/core/aes_sbox_forward_inverse_top_defines.svh =====
// ----------------------------------------------------------------------------
// AES S-box assertion macros
// Assertion wrappers for the byte substitution block; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef AES_SBOX_FORWARD_INVERSE_TOP_DEFINES_SVH
`define AES_SBOX_FORWARD_INVERSE_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Checked property, disabled while reset is high.
`define SBX_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("aes sbox check failed");

// Checked property that also holds through reset.
`define SBX_ASSERT_ALWAYS(name, clk, prop) \
   name: assert property (@(posedge clk) prop) \
      else $error("aes sbox check failed");

`else

`define SBX_ASSERT(name, clk, rst, prop)

`define SBX_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// ===== rtl/core/aes_sbx_pkg.sv =====
// ----------------------------------------------------------------------------
// AES S-box package
// Field constants, table fill types and GF(2^8) helper functions.
// ----------------------------------------------------------------------------
package aes_sbx_pkg;

   localparam int unsigned BYTE_W = 8;

   // Field polynomial x^8+x^4+x^3+x+1 and the affine offset.
   localparam logic [BYTE_W:0]   FIELD_POLY = 9'h11B;
   localparam logic [BYTE_W-1:0] FWD_CONST  = 8'h63;

   // Generator 0x03 of the multiplicative group and its inverse.
   localparam logic [BYTE_W-1:0] GEN_ELEM     = 8'h03;
   localparam logic [BYTE_W-1:0] GEN_ELEM_INV = 8'hF6;

   // Fill sequencer states.
   typedef enum logic [1:0] {
      ST_FILL  = 2'b01,
      ST_READY = 2'b10
   } fill_state_type;

   // One table pair written per cycle: fwd[plain] = subst, inv[subst] = plain.
   typedef struct packed {
      logic              wr_en;
      logic              done;
      logic [BYTE_W-1:0] plain;
      logic [BYTE_W-1:0] subst;
   } fill_wr_type;

   // Product in GF(2^8) modulo the field polynomial.
   function automatic logic [BYTE_W-1:0] gf_mul(input logic [BYTE_W-1:0] a,
                                                input logic [BYTE_W-1:0] b);
      logic [BYTE_W:0]   x;
      logic [BYTE_W-1:0] acc;
      acc = '0;
      x   = {1'b0, a};
      for (int n = 0; n < BYTE_W; n++) begin
         if (b[n]) begin
            acc = acc ^ x[BYTE_W-1:0];
         end
         x = {x[BYTE_W-1:0], 1'b0};
         if (x[BYTE_W]) begin
            x = x ^ FIELD_POLY;
         end
      end
      return acc;
   endfunction

   // Forward affine transform including the constant.
   function automatic logic [BYTE_W-1:0] fwd_affine(input logic [BYTE_W-1:0] v);
      logic [BYTE_W-1:0] r1, r2, r3, r4;
      r1 = {v[6:0], v[7]};
      r2 = {v[5:0], v[7:6]};
      r3 = {v[4:0], v[7:5]};
      r4 = {v[3:0], v[7:4]};
      return v ^ r1 ^ r2 ^ r3 ^ r4 ^ FWD_CONST;
   endfunction

endpackage

// ===== rtl/core/aes_sbx_fill.sv =====
// ----------------------------------------------------------------------------
// AES S-box table fill sequencer
// After reset, walks the powers of the generator and emits one forward and
// one inverse table entry per cycle, 256 entry pairs in all.
// ----------------------------------------------------------------------------
module aes_sbx_fill (
   input  logic                     clock,
   input  logic                     reset,
   output aes_sbx_pkg::fill_wr_type fill_wr
);
   import aes_sbx_pkg::*;

   fill_state_type    state_ff, state_in;
   logic [BYTE_W-1:0] cnt_ff, cnt_in;
   logic [BYTE_W-1:0] pow_ff, pow_in;
   logic [BYTE_W-1:0] rcp_ff, rcp_in;
   logic              last;
   logic [BYTE_W-1:0] plain;
   logic [BYTE_W-1:0] recip;

   // pow_ff holds 3^k and rcp_ff holds 3^-k, its multiplicative inverse.
   // The final step writes the zero entry, which maps to zero before affine.
   assign last  = (cnt_ff == {BYTE_W{1'b1}});
   assign plain = last ? '0 : pow_ff;
   assign recip = last ? '0 : rcp_ff;

   // Next-state logic of the sweep.
   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      pow_in   = pow_ff;
      rcp_in   = rcp_ff;
      case (state_ff)
         ST_FILL: begin
            cnt_in = cnt_ff + 1'b1;
            pow_in = gf_mul(pow_ff, GEN_ELEM);
            rcp_in = gf_mul(rcp_ff, GEN_ELEM_INV);
            if (last) begin
               state_in = ST_READY;
            end
         end
         ST_READY: begin
            state_in = ST_READY;
         end
         default: begin
            state_in = ST_FILL;
         end
      endcase
   end

   // Sweep registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
         cnt_ff   <= '0;
         pow_ff   <= 8'h01;
         rcp_ff   <= 8'h01;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         pow_ff   <= pow_in;
         rcp_ff   <= rcp_in;
      end
   end

   // Table write pair toward the memories.
   always_comb begin
      fill_wr.wr_en = (state_ff == ST_FILL);
      fill_wr.done  = (state_ff == ST_READY);
      fill_wr.plain = plain;
      fill_wr.subst = fwd_affine(recip);
   end

endmodule

// ===== rtl/core/aes_sbox_forward_inverse_top.sv =====
// ----------------------------------------------------------------------------
// AES forward and inverse S-box
// Byte substitution served from two synchronous table memories.
// ----------------------------------------------------------------------------
// Usage:
// The request channel (req_valid, req_ready) carries req_kind, 0 for the
// forward substitution and 1 for the inverse, and the byte req_data_in.
// The response channel (rsp_valid, rsp_ready) returns rsp_data_out, one
// result per request, in request order.
// The table read registered at the request transfer is the response
// register. Throughput is one byte per cycle while the receiver takes
// each response, set by the single read port of each table memory.
// After reset the block fills both tables, all 256 entry pairs, one entry
// pair per cycle, with req_ready low; then it serves requests.
// When the receiver stalls, the response holds and a new request is taken
// only in the cycle in which the held response transfers.
// ----------------------------------------------------------------------------
`include "aes_sbox_forward_inverse_top_defines.svh"

module aes_sbox_forward_inverse_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_kind,
   input  logic [aes_sbx_pkg::BYTE_W-1:0] req_data_in,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [aes_sbx_pkg::BYTE_W-1:0] rsp_data_out
);
   import aes_sbx_pkg::*;

   localparam int unsigned DEPTH = 1 << BYTE_W;

   fill_wr_type       fill_wr;
   logic [BYTE_W-1:0] fwd_mem [DEPTH];
   logic [BYTE_W-1:0] inv_mem [DEPTH];
   logic [BYTE_W-1:0] fwd_rd_ff;
   logic [BYTE_W-1:0] inv_rd_ff;
   logic              kind_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              req_xfer;

   // Table fill after reset.
   aes_sbx_fill u_fill (
      .clock   (clock),
      .reset   (reset),
      .fill_wr (fill_wr)
   );

   // A request transfers when the tables are ready and the output is free.
   assign req_ready = fill_wr.done && (!rsp_valid_ff || rsp_ready);
   assign req_xfer  = req_valid && req_ready;

   // Forward table memory.
   always_ff @(posedge clock) begin
      if (fill_wr.wr_en) begin
         fwd_mem[fill_wr.plain] <= fill_wr.subst;
      end
      if (req_xfer) begin
         fwd_rd_ff <= fwd_mem[req_data_in];
      end
   end

   // Inverse table memory.
   always_ff @(posedge clock) begin
      if (fill_wr.wr_en) begin
         inv_mem[fill_wr.subst] <= fill_wr.plain;
      end
      if (req_xfer) begin
         inv_rd_ff <= inv_mem[req_data_in];
      end
   end

   // Direction travels alongside the read.
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         kind_ff <= req_kind;
      end
   end

   // Response valid flag.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_data_out = kind_ff ? inv_rd_ff : fwd_rd_ff;

   // Checks.
   `SBX_ASSERT(a_no_req_during_fill, clock, reset, !fill_wr.done |-> !req_ready)
   `SBX_ASSERT(a_xfer_gives_rsp, clock, reset, req_xfer |=> rsp_valid)
   `SBX_ASSERT_ALWAYS(a_reset_blocks_req, clock, reset |=> (!req_ready && !rsp_valid))

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// AES forward and inverse S-box testbench
// Sends directed and random byte substitution requests through the
// valid/ready request channel. A scoreboard predicts each response from
// its own GF(2^8) inverse table and affine transforms, then compares every
// response transfer in order. Idle and stall patterns on both channels
// vary from phase to phase, and one phase holds off the receiver for a
// long stretch.
// ----------------------------------------------------------------------------
module tb;

   import aes_sbx_pkg::*;

   localparam logic       KIND_FORWARD     = 1'b0;
   localparam logic       KIND_INVERSE     = 1'b1;
   localparam logic [7:0] INV_AFFINE_CONST = 8'h05;
   localparam int         CYCLE_LIMIT      = 500000;
   localparam int         LONG_HOLD_CYCLES = 300;
   localparam int         ITEMS_PER_BURST  = 112;

   // Scoreboard: predicts the substituted byte and checks responses in order.
   class sbox_scoreboard;
      logic [7:0]  field_inverse [256];
      logic [7:0]  pending_bytes [$];
      int unsigned failures;

      function new();
         field_inverse[0] = 8'h00;
         // Find each multiplicative inverse by search over the field.
         for (int a = 1; a < 256; a++) begin
            for (int b = 1; b < 256; b++) begin
               if (gf_product(a[7:0], b[7:0]) == 8'h01) begin
                  field_inverse[a] = b[7:0];
               end
            end
         end
         failures = 0;
      endfunction

      // Product modulo the field polynomial, Horner style from the top bit.
      function logic [7:0] gf_product(logic [7:0] a, logic [7:0] b);
         logic [7:0] p;
         p = 8'h00;
         for (int i = 7; i >= 0; i--) begin
            p = {p[6:0], 1'b0} ^ (p[7] ? FIELD_POLY[7:0] : 8'h00);
            if (b[i]) begin
               p = p ^ a;
            end
         end
         return p;
      endfunction

      function logic [7:0] rotate_left(logic [7:0] v, int k);
         logic [15:0] w;
         w = {v, v} << k;
         return w[15:8];
      endfunction

      function logic [7:0] substitute_byte(logic kind, logic [7:0] data);
         logic [7:0] v;
         if (kind == KIND_FORWARD) begin
            v = field_inverse[data];
            return v ^ rotate_left(v, 1) ^ rotate_left(v, 2) ^ rotate_left(v, 3)
                     ^ rotate_left(v, 4) ^ FWD_CONST;
         end else begin
            v = rotate_left(data, 1) ^ rotate_left(data, 3) ^ rotate_left(data, 6)
                ^ INV_AFFINE_CONST;
            return field_inverse[v];
         end
      endfunction

      function void note_request(logic kind, logic [7:0] data);
         pending_bytes.push_back(substitute_byte(kind, data));
      endfunction

      function void check_response(logic [7:0] actual);
         logic [7:0] wanted;
         if (pending_bytes.size() == 0) begin
            $error("data_out: unexpected response, actual %02h", actual);
            failures++;
         end else begin
            wanted = pending_bytes.pop_front();
            if (actual !== wanted) begin
               $error("data_out mismatch: expected %02h, actual %02h", wanted, actual);
               failures++;
            end
         end
      endfunction

      function int unsigned outstanding();
         return pending_bytes.size();
      endfunction
   endclass

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_kind = 1'b0;
   logic [7:0] req_data_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_data_out;

   sbox_scoreboard sbox_check;
   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   bit          hold_request = 1'b0;
   int          hold_left = 0;
   int unsigned cycle_count = 0;

   aes_sbox_forward_inverse_top dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_kind     (req_kind),
      .req_data_in  (req_data_in),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data_out (rsp_data_out)
   );

   // Clock generation.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: checks each response transfer and drives the stall pattern.
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         sbox_check.check_response(rsp_data_out);
      end
      if (hold_request) begin
         hold_left = LONG_HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left--;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
   end

   // Offer one request, with an optional idle gap before it, and wait for
   // its transfer.
   task automatic send_request(logic kind, logic [7:0] data);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_data_in <= data;
      do begin
         @(posedge clock);
      end while (!req_ready);
      sbox_check.note_request(kind, data);
   endtask

   // Stop offering and wait until every predicted response has arrived.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sbox_check.outstanding() != 0) begin
         @(posedge clock);
      end
   endtask

   function automatic logic [7:0] random_byte();
      case ($urandom_range(0, 15))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return FWD_CONST;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Main sequence.
   initial begin
      logic [7:0] fwd_bytes [8];
      logic [7:0] inv_bytes [8];
      sbox_check = new();
      fwd_bytes = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h55, 8'hAA, 8'h53, 8'h63};
      inv_bytes = '{8'h63, 8'h00, 8'hFF, 8'h01, 8'h80, 8'h7C, 8'hED, 8'h52};

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes, zero operand of the inverse in both
      // directions, and round trips through known table pairs.
      foreach (fwd_bytes[i]) send_request(KIND_FORWARD, fwd_bytes[i]);
      foreach (inv_bytes[i]) send_request(KIND_INVERSE, inv_bytes[i]);
      wait_drained();

      // Long receiver hold-off while requests keep coming, so the block
      // backs up and stalls its request channel.
      hold_request = 1'b1;
      for (int i = 0; i < 40; i++) begin
         send_request(1'($urandom_range(0, 1)), random_byte());
      end
      wait_drained();

      // Random bursts across the idle and stall phases.
      for (int rep = 0; rep < 4; rep++) begin
         for (int phase = 0; phase < 4; phase++) begin
            case (phase)
               0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
               1: begin send_idle_pct = 49; recv_stall_pct = 0;  end
               2: begin send_idle_pct = 0;  recv_stall_pct = 49; end
               default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            for (int i = 0; i < ITEMS_PER_BURST; i++) begin
               send_request(1'($urandom_range(0, 1)), random_byte());
            end
         end
      end
      wait_drained();
      repeat (4) @(posedge clock);

      if (sbox_check.failures == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/aes_sbx_pkg.sv
rtl/core/aes_sbx_fill.sv
rtl/core/aes_sbox_forward_inverse_top.sv
tb/tb.sv
